// ===== rtl/xxhash64_stream_hasher_defines.svh =====
// Assertion macros shared by the xxHash64 checker
`ifndef XXHASH64_STREAM_HASHER_DEFINES_SVH
`define XXHASH64_STREAM_HASHER_DEFINES_SVH

// Implication in the same cycle, idle while in reset
`define XXH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xxh64 check failed");

// Implication in the next cycle, idle while in reset
`define XXH_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xxh64 check failed");

// Implication in the next cycle, also checked through reset
`define XXH_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("xxh64 check failed");

`endif

// ===== rtl/xxh64_pkg.sv =====
// Constants and shared types of the xxHash64 stream hasher
`timescale 1ns / 1ps

package xxh64_pkg;

  // xxHash64 primes
  localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
  localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

  // Request to the shared multiplier: hold run and operands until done
  typedef struct packed {
    logic        run;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // Multiplier response: low 64 bits of the product, valid while done
  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

endpackage

// ===== rtl/xxh64_if.sv =====
// Valid/ready channel interfaces of the xxHash64 stream hasher
`timescale 1ns / 1ps

interface xxh64_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last;

  modport source (output valid, output data_word, output byte_count, output last,
                  input ready);
  modport sink (input valid, input data_word, input byte_count, input last,
                output ready);
endinterface

interface xxh64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

interface xxh64_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_seed;

  modport source (output valid, output hash_seed, input ready);
  modport sink (input valid, input hash_seed, output ready);
endinterface

// ===== rtl/xxh64_mul.sv =====
// Shared 64x64 low-half multiplier built from one 32x32 multiplier over the steps LL, LH, HL and SUM
`timescale 1ns / 1ps

module xxh64_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  xxh64_pkg::mul_req_t req,
  output xxh64_pkg::mul_rsp_t rsp
);

  typedef enum logic [1:0] {
    STEP_LL,
    STEP_LH,
    STEP_HL,
    STEP_SUM
  } step_t;

  step_t       step_r;
  logic [63:0] prod_r;
  logic [63:0] lo_r;
  logic [31:0] x;
  logic [31:0] y;

  // Pick the partial product for this step
  always_comb begin
    unique case (step_r)
      STEP_LL: begin
        x = req.a[31:0];
        y = req.b[31:0];
      end
      STEP_LH: begin
        x = req.a[31:0];
        y = req.b[63:32];
      end
      default: begin
        x = req.a[63:32];
        y = req.b[31:0];
      end
    endcase
  end

  // Advance the step counter and accumulate partial products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_LL;
    end else if (req.run) begin
      unique case (step_r)
        STEP_LL:  step_r <= STEP_LH;
        STEP_LH:  step_r <= STEP_HL;
        STEP_HL:  step_r <= STEP_SUM;
        STEP_SUM: step_r <= STEP_LL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.run) begin
      prod_r <= 64'(x) * 64'(y);
      unique case (step_r)
        STEP_LH: lo_r <= prod_r;
        STEP_HL: lo_r <= lo_r + {prod_r[31:0], 32'h0};
        default: lo_r <= lo_r;
      endcase
    end
  end

  // Final cross term lands in the upper half
  assign rsp.done = req.run && (step_r == STEP_SUM);
  assign rsp.p    = lo_r + {prod_r[31:0], 32'h0};

endmodule

// ===== rtl/xxhash64_stream_hasher.sv =====
// Top level of the seeded xxHash64 stream hasher
`timescale 1ns / 1ps

// Seeded xxHash64 over a message given as little-endian 64-bit words, one per
// beat; the beat flagged last carries 0 to 8 valid bytes (byte_count, larger
// values count as 8) and produces one hash on the out channel. All products
// run through a single 32x32 multiplier, one 64-bit product at a time, and
// the input is not ready while a word is in work. A word that does not close
// a 32-byte stripe is stored as pending. A word that closes a stripe runs a
// round on four lanes, two products each. The last word is accepted, runs a
// round if it closes a stripe, picks the path and adds the length, merges the
// lanes (only at 32 bytes or more), folds each pending 8-byte word, decodes
// the tail, folds a full final word or a 4-byte chunk, then each single byte,
// and finishes; the hash then waits, if need be, for the result register to
// empty. The result register lets the next message start while a hash waits.
// A seed write is taken only while idle; it restarts the current message from
// the new seed.
module xxhash64_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  xxh64_cfg_if.sink   cfg_bus,
  xxh64_in_if.sink    in_bus,
  xxh64_out_if.source out_bus
);

  typedef logic [3:0][63:0] lane_vec_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RND_M1,
    ST_RND_M2,
    ST_FIN,
    ST_CONV,
    ST_MRG_M1,
    ST_MRG_M2,
    ST_MRG_M3,
    ST_LEN,
    ST_F8_M1,
    ST_F8_M2,
    ST_F8_M3,
    ST_TAIL,
    ST_Q4_M1,
    ST_Q4_M2,
    ST_BYTE,
    ST_B_M1,
    ST_B_M2,
    ST_AV_M1,
    ST_AV_M2,
    ST_OUT
  } state_t;

  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic lane_vec_t lanes_from_seed(input logic [63:0] seed);
    lane_vec_t l;
    l[0] = seed + xxh64_pkg::PRIME1 + xxh64_pkg::PRIME2;
    l[1] = seed + xxh64_pkg::PRIME2;
    l[2] = seed;
    l[3] = seed - xxh64_pkg::PRIME1;
    return l;
  endfunction

  state_t              state_r;
  logic [63:0]         seed_r;
  lane_vec_t           acc_r;
  logic [63:0]         pend_r [3];
  logic [1:0]          pos_r;
  logic [63:0]         len_r;
  logic [63:0]         word_r;
  logic [3:0]          n_r;
  logic [1:0]          tail_r;
  logic                last_r;
  logic [1:0]          k_r;
  logic [3:0]          off_r;
  logic [63:0]         h_r;
  logic [63:0]         t_r;
  logic                out_valid_r;
  logic [63:0]         out_hash_r;

  logic                in_fire;
  logic                cfg_fire;
  logic [3:0]          nsat;
  logic [63:0]         word_masked;
  logic [63:0]         lane_word;
  logic [63:0]         conv_term;
  logic [7:0]          byte_sel;
  logic                more_pend;
  xxh64_pkg::mul_req_t mul_req;
  xxh64_pkg::mul_rsp_t mul_rsp;

  // Handshakes: both channels open only while idle, seed writes win
  assign cfg_bus.ready = (state_r == ST_IDLE);
  assign in_bus.ready  = (state_r == ST_IDLE) && !cfg_bus.valid;
  assign cfg_fire      = cfg_bus.valid && cfg_bus.ready;
  assign in_fire       = in_bus.valid && in_bus.ready;

  assign out_bus.valid      = out_valid_r;
  assign out_bus.hash_value = out_hash_r;

  // Saturate the byte count and drop bytes past it
  assign nsat = (in_bus.byte_count > 4'd8) ? 4'd8 : in_bus.byte_count;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      word_masked[b*8 +: 8] = (4'(b) < nsat) ? in_bus.data_word[b*8 +: 8] : 8'h00;
    end
  end

  // Operand selects
  assign lane_word = (k_r == 2'd3) ? word_r : pend_r[k_r];
  assign byte_sel  = word_r[off_r[2:0]*8 +: 8];
  assign more_pend = ({1'b0, k_r} + 3'd1) < {1'b0, tail_r};

  always_comb begin
    unique case (k_r)
      2'd0: conv_term = rotl(acc_r[0], 1);
      2'd1: conv_term = rotl(acc_r[1], 7);
      2'd2: conv_term = rotl(acc_r[2], 12);
      2'd3: conv_term = rotl(acc_r[3], 18);
    endcase
  end

  // Drive the shared multiplier from the current step
  always_comb begin
    mul_req.run = 1'b1;
    mul_req.a   = h_r;
    mul_req.b   = xxh64_pkg::PRIME1;
    unique case (state_r)
      ST_RND_M1, ST_F8_M1: begin
        mul_req.a = lane_word;
        mul_req.b = xxh64_pkg::PRIME2;
      end
      ST_MRG_M1: begin
        mul_req.a = acc_r[k_r];
        mul_req.b = xxh64_pkg::PRIME2;
      end
      ST_RND_M2, ST_MRG_M2, ST_F8_M2: begin
        mul_req.a = rotl(t_r, 31);
      end
      ST_MRG_M3, ST_F8_M3, ST_B_M2: begin
        mul_req.a = h_r;
      end
      ST_Q4_M1: begin
        mul_req.a = {32'h0, word_r[31:0]};
      end
      ST_Q4_M2: begin
        mul_req.b = xxh64_pkg::PRIME2;
      end
      ST_B_M1: begin
        mul_req.a = {56'h0, byte_sel};
        mul_req.b = xxh64_pkg::PRIME5;
      end
      ST_AV_M1: begin
        mul_req.a = h_r ^ (h_r >> 33);
        mul_req.b = xxh64_pkg::PRIME2;
      end
      ST_AV_M2: begin
        mul_req.a = h_r ^ (h_r >> 29);
        mul_req.b = xxh64_pkg::PRIME3;
      end
      default: begin
        mul_req.run = 1'b0;
      end
    endcase
  end

  xxh64_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= 64'h0;
      acc_r       <= lanes_from_seed(64'h0);
      pos_r       <= 2'd0;
      len_r       <= 64'h0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once the beat is taken, unless a new hash replaces it
      if (out_valid_r && out_bus.ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (cfg_fire) begin
            seed_r <= cfg_bus.hash_seed;
            acc_r  <= lanes_from_seed(cfg_bus.hash_seed);
            pos_r  <= 2'd0;
            len_r  <= 64'h0;
          end else if (in_fire) begin
            word_r <= in_bus.last ? word_masked : in_bus.data_word;
            last_r <= in_bus.last;
            k_r    <= 2'd0;
            if (!in_bus.last) begin
              len_r <= len_r + 64'd8;
              if (pos_r == 2'd3) begin
                pos_r   <= 2'd0;
                state_r <= ST_RND_M1;
              end else begin
                pend_r[pos_r] <= in_bus.data_word;
                pos_r         <= pos_r + 2'd1;
              end
            end else begin
              len_r <= len_r + 64'(nsat);
              if (nsat == 4'd8 && pos_r == 2'd3) begin
                tail_r  <= 2'd0;
                n_r     <= 4'd0;
                state_r <= ST_RND_M1;
              end else begin
                tail_r  <= pos_r;
                n_r     <= nsat;
                state_r <= ST_FIN;
              end
            end
          end
        end

        // Stripe round on each lane
        ST_RND_M1: begin
          if (mul_rsp.done) begin
            t_r     <= acc_r[k_r] + mul_rsp.p;
            state_r <= ST_RND_M2;
          end
        end
        ST_RND_M2: begin
          if (mul_rsp.done) begin
            acc_r[k_r] <= mul_rsp.p;
            k_r        <= k_r + 2'd1;
            if (k_r == 2'd3) begin
              state_r <= last_r ? ST_FIN : ST_IDLE;
            end else begin
              state_r <= ST_RND_M1;
            end
          end
        end

        // Choose lane merge or short-message start
        ST_FIN: begin
          k_r <= 2'd0;
          if (len_r[63:5] != 59'h0) begin
            h_r     <= 64'h0;
            state_r <= ST_CONV;
          end else begin
            h_r     <= acc_r[2] + xxh64_pkg::PRIME5;
            state_r <= ST_LEN;
          end
        end
        ST_CONV: begin
          h_r <= h_r + conv_term;
          k_r <= k_r + 2'd1;
          if (k_r == 2'd3) begin
            state_r <= ST_MRG_M1;
          end
        end
        ST_MRG_M1: begin
          if (mul_rsp.done) begin
            t_r     <= mul_rsp.p;
            state_r <= ST_MRG_M2;
          end
        end
        ST_MRG_M2: begin
          if (mul_rsp.done) begin
            h_r     <= h_r ^ mul_rsp.p;
            state_r <= ST_MRG_M3;
          end
        end
        ST_MRG_M3: begin
          if (mul_rsp.done) begin
            h_r <= mul_rsp.p + xxh64_pkg::PRIME4;
            k_r <= k_r + 2'd1;
            state_r <= (k_r == 2'd3) ? ST_LEN : ST_MRG_M1;
          end
        end

        // Add the length, then fold pending words
        ST_LEN: begin
          h_r     <= h_r + len_r;
          k_r     <= 2'd0;
          state_r <= (tail_r != 2'd0) ? ST_F8_M1 : ST_TAIL;
        end
        ST_F8_M1: begin
          if (mul_rsp.done) begin
            t_r     <= mul_rsp.p;
            state_r <= ST_F8_M2;
          end
        end
        ST_F8_M2: begin
          if (mul_rsp.done) begin
            h_r     <= rotl(h_r ^ mul_rsp.p, 27);
            state_r <= ST_F8_M3;
          end
        end
        ST_F8_M3: begin
          if (mul_rsp.done) begin
            h_r <= mul_rsp.p + xxh64_pkg::PRIME4;
            priority if (k_r == 2'd3) begin
              state_r <= ST_BYTE;
            end else if (more_pend) begin
              k_r     <= k_r + 2'd1;
              state_r <= ST_F8_M1;
            end else begin
              state_r <= ST_TAIL;
            end
          end
        end

        // Final word: full 8 bytes, a 4-byte chunk, or bytes only
        ST_TAIL: begin
          priority if (n_r == 4'd8) begin
            k_r     <= 2'd3;
            off_r   <= 4'd8;
            state_r <= ST_F8_M1;
          end else if (n_r >= 4'd4) begin
            off_r   <= 4'd4;
            state_r <= ST_Q4_M1;
          end else begin
            off_r   <= 4'd0;
            state_r <= ST_BYTE;
          end
        end
        ST_Q4_M1: begin
          if (mul_rsp.done) begin
            h_r     <= rotl(h_r ^ mul_rsp.p, 23);
            state_r <= ST_Q4_M2;
          end
        end
        ST_Q4_M2: begin
          if (mul_rsp.done) begin
            h_r     <= mul_rsp.p + xxh64_pkg::PRIME3;
            state_r <= ST_BYTE;
          end
        end
        ST_BYTE: begin
          state_r <= (off_r < n_r) ? ST_B_M1 : ST_AV_M1;
        end
        ST_B_M1: begin
          if (mul_rsp.done) begin
            h_r     <= rotl(h_r ^ mul_rsp.p, 11);
            state_r <= ST_B_M2;
          end
        end
        ST_B_M2: begin
          if (mul_rsp.done) begin
            h_r     <= mul_rsp.p;
            off_r   <= off_r + 4'd1;
            state_r <= ST_BYTE;
          end
        end

        // Avalanche
        ST_AV_M1: begin
          if (mul_rsp.done) begin
            h_r     <= mul_rsp.p;
            state_r <= ST_AV_M2;
          end
        end
        ST_AV_M2: begin
          if (mul_rsp.done) begin
            h_r     <= mul_rsp.p ^ (mul_rsp.p >> 32);
            state_r <= ST_OUT;
          end
        end

        // Hand the hash to the result register and restart the lanes
        ST_OUT: begin
          if (!out_valid_r || out_bus.ready) begin
            out_hash_r  <= h_r;
            out_valid_r <= 1'b1;
            acc_r       <= lanes_from_seed(seed_r);
            pos_r       <= 2'd0;
            len_r       <= 64'h0;
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/xxh64_checker.sv =====
// Port-level checker for the xxHash64 stream hasher, bound to the top level
`timescale 1ns / 1ps
`include "xxhash64_stream_hasher_defines.svh"

module xxh64_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_hash,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // A stalled result beat holds its hash
  `XXH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_hash))

  // A last beat starts the finish, so the input closes right after
  `XXH_ASSERT_NXT(a_last_busy, in_valid && in_ready && in_last, !in_ready)

  // Input beats and seed writes never land together
  `XXH_ASSERT_IMP(a_no_overlap, in_valid && in_ready, !(cfg_valid && cfg_ready))

  // Reset empties the result register
  `XXH_ASSERT_RST(a_rst_empty, !rst_n, !out_valid)

endmodule

bind xxhash64_stream_hasher xxh64_checker u_xxh64_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .in_last   (in_bus.last),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_hash  (out_bus.hash_value),
  .cfg_valid (cfg_bus.valid),
  .cfg_ready (cfg_bus.ready)
);
